/* rtl/vector_cumulative_average_macros.svh */
// Assertion macros for the vector cumulative average block.
// Used by the checker; expects clk and rst in scope where expanded.
`ifndef VECTOR_CUMULATIVE_AVERAGE_MACROS_SVH
`define VECTOR_CUMULATIVE_AVERAGE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define VCA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define VCA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication, checked in reset as well.
`define VCA_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/vca_pkg.sv */
// Shared types and constants for the vector cumulative average block.
// No dependencies.
package vca_pkg;

  localparam int VECTOR_MAX     = 64;
  localparam int SAMPLE_WIDTH   = 16;
  localparam int COUNT_WIDTH    = 32;
  localparam int SUM_WIDTH      = SAMPLE_WIDTH + COUNT_WIDTH;
  localparam int POS_WIDTH      = $clog2(VECTOR_MAX);
  localparam int SIZE_WIDTH     = 7;
  localparam int DEC_WIDTH      = 16;
  localparam int CFG_IDX_WIDTH  = 2;
  localparam int CFG_DATA_WIDTH = 16;
  localparam int OUT_DATA_WIDTH = ((SAMPLE_WIDTH + POS_WIDTH + 7) / 8) * 8;
  localparam int STEP_WIDTH     = $clog2(SUM_WIDTH);

  localparam logic [CFG_IDX_WIDTH-1:0] CFG_VECTOR_SIZE   = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_DECIMATION    = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_OUTPUT_ENABLE = 2'd2;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_ADD  = 5'b00010,
    ST_ABS  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

endpackage

/* rtl/vca_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module vca_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/vector_cumulative_average.sv */
// Vector cumulative average: per-position running sums in RAM, iterative divide.
// Depends on vca_pkg and vca_ram.
// Emitting sample: ST_ADD, ST_ABS, the ST_DIV loop and ST_FIN, which loads the word once the output is free;
// the next word is accepted back in ST_IDLE. Non-emitting sample: ST_ADD, then ST_IDLE; clear word: ST_IDLE only.
// Sync reset: registers to 1/1/1, count, position, phase and sum valid bits to zero.
// Output register lets a new word in while the last result waits for m_axis_tready.
module vector_cumulative_average (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [vca_pkg::SAMPLE_WIDTH-1:0]    s_axis_tdata,  // sample
  input  logic                                s_axis_tuser,  // kind
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [vca_pkg::OUT_DATA_WIDTH-1:0]  m_axis_tdata,  // average, element_index, pad
  output logic                                m_axis_tlast,
  input  logic                                cfg_we,
  input  logic [vca_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
  input  logic [vca_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
  import vca_pkg::*;

  state_t state;

  logic [SIZE_WIDTH-1:0]  vector_size;
  logic [DEC_WIDTH-1:0]   decimation;
  logic                   output_enable;

  logic [COUNT_WIDTH-1:0] count;
  logic [POS_WIDTH-1:0]   position;
  logic [DEC_WIDTH-1:0]   phase;
  logic [VECTOR_MAX-1:0]  valid;

  logic [POS_WIDTH-1:0]    item_pos;
  logic signed [SAMPLE_WIDTH-1:0] item_sample;
  logic                    item_last;
  logic                    item_emit;
  logic signed [SUM_WIDTH-1:0] sum;
  logic [SUM_WIDTH-1:0]    quo;
  logic [COUNT_WIDTH-1:0]  rem;
  logic [STEP_WIDTH-1:0]   step;

  logic [SIZE_WIDTH-1:0]  size_eff;
  logic [DEC_WIDTH-1:0]   dec_eff;
  logic [POS_WIDTH-1:0]   pos_eff;
  logic                   last_vector;
  logic                   last_elem;
  logic                   accept;

  logic [SUM_WIDTH-1:0]   rdata;
  logic [SUM_WIDTH-1:0]   old_sum;
  logic [SUM_WIDTH:0]     sum_wide;
  logic [SUM_WIDTH-1:0]   sum_next;
  logic [COUNT_WIDTH:0]   trial;
  logic                   trial_ok;
  logic signed [SAMPLE_WIDTH-1:0] avg;
  logic                   out_free;

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    if (vector_size == '0) begin
      size_eff = SIZE_WIDTH'(1);
    end else if (vector_size > SIZE_WIDTH'(VECTOR_MAX)) begin
      size_eff = SIZE_WIDTH'(VECTOR_MAX);
    end else begin
      size_eff = vector_size;
    end
    dec_eff     = (decimation == '0) ? DEC_WIDTH'(1) : decimation;
    pos_eff     = ({1'b0, position} >= size_eff) ? '0 : position;
    last_vector = phase >= (dec_eff - DEC_WIDTH'(1));
    last_elem   = ({1'b0, pos_eff} + SIZE_WIDTH'(1)) >= size_eff;
  end

  // saturating add of the sample to the stored sum
  always_comb begin
    old_sum  = valid[item_pos] ? rdata : '0;
    sum_wide = {old_sum[SUM_WIDTH-1], old_sum}
             + (SUM_WIDTH+1)'(signed'(item_sample));
    if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
      sum_next = sum_wide[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                     : {1'b0, {(SUM_WIDTH-1){1'b1}}};
    end else begin
      sum_next = sum_wide[SUM_WIDTH-1:0];
    end
  end

  // restoring divide step
  always_comb begin
    trial    = {rem, quo[SUM_WIDTH-1]};
    trial_ok = trial >= {1'b0, count};
  end

  // saturate quotient to sample range
  always_comb begin
    if (count == '0) begin
      avg = '0;
    end else if (sum < 0) begin
      if (quo >= SUM_WIDTH'(1) << (SAMPLE_WIDTH - 1)) begin
        avg = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
      end else begin
        avg = -signed'(quo[SAMPLE_WIDTH-1:0]);
      end
    end else begin
      if (quo >= {{(SUM_WIDTH-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}}) begin
        avg = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
      end else begin
        avg = signed'(quo[SAMPLE_WIDTH-1:0]);
      end
    end
  end

  vca_ram #(
    .WIDTH (SUM_WIDTH),
    .DEPTH (VECTOR_MAX)
  ) u_sums (
    .clk   (clk),
    .we    (state == ST_ADD),
    .waddr (item_pos),
    .wdata (sum_next),
    .raddr (pos_eff),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vector_size   <= SIZE_WIDTH'(1);
      decimation    <= DEC_WIDTH'(1);
      output_enable <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VECTOR_SIZE:   vector_size   <= cfg_data[SIZE_WIDTH-1:0];
        CFG_DECIMATION:    decimation    <= cfg_data[DEC_WIDTH-1:0];
        CFG_OUTPUT_ENABLE: output_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      count         <= '0;
      position      <= '0;
      phase         <= '0;
      valid         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (state == ST_FIN && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (s_axis_tuser == KIND_CLEAR) begin
              count    <= '0;
              position <= '0;
              phase    <= '0;
              valid    <= '0;
            end else begin
              if (pos_eff == '0 && count != '1) begin
                count <= count + COUNT_WIDTH'(1);
              end
              if (last_elem) begin
                position <= '0;
                phase    <= last_vector ? '0 : phase + DEC_WIDTH'(1);
              end else begin
                position <= pos_eff + POS_WIDTH'(1);
              end
              state <= ST_ADD;
            end
          end
        end
        ST_ADD: begin
          valid[item_pos] <= 1'b1;
          state <= item_emit ? ST_ABS : ST_IDLE;
        end
        ST_ABS: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (step == '0) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_pos    <= pos_eff;
      item_sample <= signed'(s_axis_tdata);
      item_last   <= last_elem;
      item_emit   <= last_vector && output_enable;
    end
    if (state == ST_ADD) begin
      sum <= signed'(sum_next);
    end
    if (state == ST_ABS) begin
      quo  <= (sum < 0) ? SUM_WIDTH'(-sum) : SUM_WIDTH'(sum);
      rem  <= '0;
      step <= STEP_WIDTH'(SUM_WIDTH - 1);
    end
    if (state == ST_DIV) begin
      quo  <= {quo[SUM_WIDTH-2:0], trial_ok};
      rem  <= trial_ok ? COUNT_WIDTH'(trial - {1'b0, count}) : trial[COUNT_WIDTH-1:0];
      step <= step - STEP_WIDTH'(1);
    end
    if (state == ST_FIN && out_free) begin
      m_axis_tdata <= {{(OUT_DATA_WIDTH-SAMPLE_WIDTH-POS_WIDTH){1'b0}}, item_pos, avg};
      m_axis_tlast <= item_last;
    end
  end

endmodule

/* rtl/vca_checker.sv */
// Port-level checker for the vector cumulative average block, bound to the top level.
// Depends on vca_pkg and vector_cumulative_average_macros.svh.
`include "vector_cumulative_average_macros.svh"

module vca_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_axis_tvalid,
  input logic                                s_axis_tready,
  input logic                                s_axis_tuser,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [vca_pkg::OUT_DATA_WIDTH-1:0]  m_axis_tdata,
  input logic                                m_axis_tlast
);
  import vca_pkg::*;

  logic                      in_sample;
  logic                      in_clear;
  logic                      out_stall;
  logic [OUT_DATA_WIDTH:0]   out_word;

  assign in_sample = s_axis_tvalid && s_axis_tready && s_axis_tuser == KIND_SAMPLE;
  assign in_clear  = s_axis_tvalid && s_axis_tready && s_axis_tuser == KIND_CLEAR;
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_word  = {m_axis_tlast, m_axis_tdata};

  // a sample keeps the block busy once accepted
  `VCA_ASSERT_NEXT(a_sample_busy, in_sample, !s_axis_tready, "ready held after sample word")

  // a clear word completes at once
  `VCA_ASSERT_NEXT(a_clear_fast, in_clear, s_axis_tready, "block busy after clear word")

  // reset empties the output register
  `VCA_ASSERT_NEXT_ALWAYS(a_rst_out, rst, !m_axis_tvalid, "output valid after reset")

  // stalled result holds
  `VCA_ASSERT_NEXT(a_hold, out_stall, m_axis_tvalid && $stable(out_word), "stalled word changed")

endmodule

bind vector_cumulative_average vca_checker u_vca_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

/* dv/vca_average_checker.sv */
// Checker for vector_cumulative_average: tracks register writes and input words,
// predicts each emitted average word and compares it with the output stream.
// Depends on vca_pkg.
module vca_average_checker
  import vca_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  input  logic                       s_axis_tready,
  input  logic [SAMPLE_WIDTH-1:0]    s_axis_tdata,  // sample
  input  logic                       s_axis_tuser,  // kind
  input  logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  input  logic [OUT_DATA_WIDTH-1:0]  m_axis_tdata,  // average, element_index, pad
  input  logic                       m_axis_tlast,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_WIDTH-1:0]   cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
  output int                         pending,
  output int                         failures
);

  localparam longint SUM_MAX = (longint'(1) << (SUM_WIDTH - 1)) - 1;
  localparam longint SUM_MIN = -SUM_MAX - 1;
  localparam int PAD_LSB = SAMPLE_WIDTH + POS_WIDTH;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] average;
    logic [POS_WIDTH-1:0]           element_index;
    logic                           last;
  } avg_word_t;

  logic [SIZE_WIDTH-1:0]  size_reg;
  logic [DEC_WIDTH-1:0]   dec_reg;
  logic                   enable_reg;
  longint                 elem_sum [VECTOR_MAX];
  logic [COUNT_WIDTH-1:0] vec_count;
  int unsigned            elem_pos;
  logic [DEC_WIDTH-1:0]   dec_phase;
  avg_word_t              expected_averages [$];

  task automatic clear_sums;
    foreach (elem_sum[i]) elem_sum[i] = 0;
    vec_count = '0;
    elem_pos  = 0;
    dec_phase = '0;
  endtask

  task automatic accumulate_sample(input logic [SAMPLE_WIDTH-1:0] smp);
    int unsigned size;
    int unsigned dec;
    int unsigned pos;
    longint      s;
    longint      total;
    longint      mag;
    longint      cnt;
    longint      q;
    longint      avg;
    logic        last_vector;
    logic        last_elem;
    avg_word_t   w;
    size = (size_reg == 0) ? 1 : (size_reg > VECTOR_MAX) ? VECTOR_MAX : size_reg;
    dec  = (dec_reg == 0) ? 1 : dec_reg;
    pos  = (elem_pos >= size) ? 0 : elem_pos;
    if (pos == 0 && vec_count != '1) vec_count++;

    s = $signed(smp);
    total = elem_sum[pos] + s;
    if (total > SUM_MAX) total = SUM_MAX;
    else if (total < SUM_MIN) total = SUM_MIN;
    elem_sum[pos] = total;

    mag = (total < 0) ? -total : total;
    cnt = vec_count;
    q = (cnt != 0) ? mag / cnt : 0;
    if (total < 0) avg = (q >= 32768) ? -32768 : -q;
    else avg = (q >= 32767) ? 32767 : q;

    last_vector = dec_phase >= dec - 1;
    last_elem   = pos + 1 >= size;
    if (last_elem) begin
      elem_pos  = 0;
      dec_phase = last_vector ? '0 : dec_phase + 1'b1;
    end else begin
      elem_pos = pos + 1;
    end

    if (last_vector && enable_reg) begin
      w.average       = avg[SAMPLE_WIDTH-1:0];
      w.element_index = POS_WIDTH'(pos);
      w.last          = last_elem;
      expected_averages.push_back(w);
    end
  endtask

  always @(posedge clk) begin
    avg_word_t                 want;
    logic [OUT_DATA_WIDTH-1:0] got_pad;
    logic                      bad;
    bad = 1'b0;
    if (rst) begin
      size_reg   = SIZE_WIDTH'(1);
      dec_reg    = DEC_WIDTH'(1);
      enable_reg = 1'b1;
      clear_sums();
      expected_averages.delete();
      failures <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_VECTOR_SIZE:   size_reg = cfg_data[SIZE_WIDTH-1:0];
          CFG_DECIMATION:    dec_reg = cfg_data[DEC_WIDTH-1:0];
          CFG_OUTPUT_ENABLE: enable_reg = cfg_data[0];
          default: ;
        endcase
      end

      // compare before predicting so a new expectation never pairs with an older word
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_averages.size() == 0) begin
          bad = 1'b1;
          $error("result word with no expectation waiting: tdata %h tlast %b",
                 m_axis_tdata, m_axis_tlast);
        end else begin
          want = expected_averages.pop_front();
          got_pad = m_axis_tdata >> PAD_LSB;
          if (m_axis_tdata[SAMPLE_WIDTH-1:0] !== want.average) begin
            bad = 1'b1;
            $error("average: expected %0d, got %0d", $signed(want.average),
                   $signed(m_axis_tdata[SAMPLE_WIDTH-1:0]));
          end
          if (m_axis_tdata[PAD_LSB-1:SAMPLE_WIDTH] !== want.element_index) begin
            bad = 1'b1;
            $error("element_index: expected %0d, got %0d", want.element_index,
                   m_axis_tdata[PAD_LSB-1:SAMPLE_WIDTH]);
          end
          if (m_axis_tlast !== want.last) begin
            bad = 1'b1;
            $error("last: expected %b, got %b", want.last, m_axis_tlast);
          end
          if (got_pad !== '0) begin
            bad = 1'b1;
            $error("pad: expected 0, got %h", got_pad);
          end
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == KIND_CLEAR) clear_sums();
        else accumulate_sample(s_axis_tdata);
      end

      if (bad) failures <= failures + 1;
    end
    pending <= expected_averages.size();
  end

endmodule

/* dv/vector_cumulative_average_test.sv */
// Top of the vector_cumulative_average testbench: clock, reset, register writes and
// randomized input/output flow control; the verdict comes from vca_average_checker.
// Depends on vca_pkg, vector_cumulative_average and vca_average_checker.
module vector_cumulative_average_test;
  import vca_pkg::*;

  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 64;
  localparam int TOTAL_WORDS  = 1220;
  localparam int CALM_WORDS   = 200;
  localparam int PHASE_CAP    = 192;

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [SAMPLE_WIDTH-1:0]   s_axis_tdata = '0;
  logic                      s_axis_tuser = KIND_SAMPLE;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [OUT_DATA_WIDTH-1:0] m_axis_tdata;
  logic                      m_axis_tlast;
  logic                      cfg_we = 1'b0;
  logic [CFG_IDX_WIDTH-1:0]  cfg_index = '0;
  logic [CFG_DATA_WIDTH-1:0] cfg_data = '0;

  int pending;
  int failures;
  int idle_cycles = 0;
  int words_sent = 0;
  int stall_left = 0;
  bit calm = 1'b0;

  // settings as last written, to size the random phases
  int unsigned cur_size = 1;
  int unsigned cur_dec = 1;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  vector_cumulative_average DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  vca_average_checker average_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .pending       (pending),
    .failures      (failures)
  );

  // output back-pressure in random bursts
  always @(negedge clk) begin
    if (calm || rst) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= $urandom_range(0, 3);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("vector_cumulative_average regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_word(input logic kind, input logic [SAMPLE_WIDTH-1:0] smp);
    @(negedge clk);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    s_axis_tuser  <= kind;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    words_sent++;
  endtask

  // let every expected word out, then give a silent word time to finish
  task automatic drain;
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
                           input logic [CFG_DATA_WIDTH-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_VECTOR_SIZE) cur_size = value[SIZE_WIDTH-1:0];
    if (idx == CFG_DECIMATION) cur_dec = value;
  endtask

  function automatic logic [SAMPLE_WIDTH-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      default: return SAMPLE_WIDTH'($urandom);
    endcase
  endfunction

  task automatic random_phase;
    int unsigned eff_size;
    int unsigned eff_dec;
    int unsigned n;
    drain;
    if ($urandom_range(0, 1) == 0) begin
      case ($urandom_range(0, 9))
        0:       write_reg(CFG_VECTOR_SIZE, CFG_DATA_WIDTH'(0));
        1:       write_reg(CFG_VECTOR_SIZE, CFG_DATA_WIDTH'(VECTOR_MAX));
        2:       write_reg(CFG_VECTOR_SIZE,
                           CFG_DATA_WIDTH'($urandom_range(VECTOR_MAX + 1, 127)));
        default: write_reg(CFG_VECTOR_SIZE, CFG_DATA_WIDTH'($urandom_range(1, 8)));
      endcase
    end
    if ($urandom_range(0, 1) == 0) begin
      case ($urandom_range(0, 9))
        0:       write_reg(CFG_DECIMATION, CFG_DATA_WIDTH'(0));
        1:       write_reg(CFG_DECIMATION, CFG_DATA_WIDTH'($urandom_range(4, 12)));
        default: write_reg(CFG_DECIMATION, CFG_DATA_WIDTH'($urandom_range(1, 3)));
      endcase
    end
    if ($urandom_range(0, 2) == 0)
      write_reg(CFG_OUTPUT_ENABLE, CFG_DATA_WIDTH'($urandom_range(0, 7) != 0));
    eff_size = (cur_size == 0) ? 1 : (cur_size > VECTOR_MAX) ? VECTOR_MAX : cur_size;
    eff_dec  = (cur_dec == 0) ? 1 : cur_dec;
    // mostly whole vectors, sometimes a ragged tail
    if ($urandom_range(0, 3) != 0) n = eff_size * $urandom_range(1, 3 * eff_dec);
    else n = $urandom_range(1, 3 * eff_size * eff_dec);
    if (n > PHASE_CAP) n = PHASE_CAP;
    repeat (n) begin
      if ($urandom_range(0, 49) == 0) send_word(KIND_CLEAR, SAMPLE_WIDTH'($urandom));
      else send_word(KIND_SAMPLE, pick_sample());
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: one-element vectors, every word emitted
    send_word(KIND_SAMPLE, 16'h7FFF);
    send_word(KIND_SAMPLE, 16'h8000);
    send_word(KIND_SAMPLE, 16'hFFFF);
    send_word(KIND_SAMPLE, 16'h0001);
    send_word(KIND_CLEAR, SAMPLE_WIDTH'($urandom));

    // zero size behaves as one
    drain;
    write_reg(CFG_VECTOR_SIZE, CFG_DATA_WIDTH'(0));
    send_word(KIND_SAMPLE, 16'h8000);
    send_word(KIND_SAMPLE, 16'h7FFF);

    // oversize vector clamps to the maximum, zero decimation behaves as one
    drain;
    write_reg(CFG_VECTOR_SIZE, CFG_DATA_WIDTH'(100));
    write_reg(CFG_DECIMATION, CFG_DATA_WIDTH'(0));
    repeat (3) send_word(KIND_SAMPLE, SAMPLE_WIDTH'($urandom));

    // shrink below the current position, then build up a decimation phase
    drain;
    write_reg(CFG_VECTOR_SIZE, CFG_DATA_WIDTH'(2));
    write_reg(CFG_DECIMATION, CFG_DATA_WIDTH'(4));
    repeat (4) send_word(KIND_SAMPLE, SAMPLE_WIDTH'($urandom));

    // lower decimation under the phase, output off
    drain;
    write_reg(CFG_DECIMATION, CFG_DATA_WIDTH'(2));
    write_reg(CFG_OUTPUT_ENABLE, CFG_DATA_WIDTH'(0));
    repeat (2) send_word(KIND_SAMPLE, SAMPLE_WIDTH'($urandom));

    drain;
    write_reg(CFG_OUTPUT_ENABLE, CFG_DATA_WIDTH'(1));
    repeat (4) send_word(KIND_SAMPLE, SAMPLE_WIDTH'($urandom));

    drain;
    write_reg(CFG_DECIMATION, 16'hFFFF);
    repeat (2) send_word(KIND_SAMPLE, SAMPLE_WIDTH'($urandom));
    send_word(KIND_CLEAR, SAMPLE_WIDTH'($urandom));

    while (words_sent < TOTAL_WORDS) begin
      if (words_sent >= TOTAL_WORDS - CALM_WORDS) calm = 1'b1;
      random_phase();
    end

    drain;
    if (failures == 0 && pending == 0) begin
      $display("vector_cumulative_average regression: pass");
    end else begin
      $display("vector_cumulative_average regression: fail");
    end
    $finish;
  end

endmodule
